// ===== rtl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types, widths and codes for the positional insert/delete list.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // request and result field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // stream packing
  localparam int IN_BITS  = OP_W + POS_W + WORD_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = WORD_W + COUNT_W + STATUS_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [OP_W-1:0] OP_READ       = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;   // open a gap at idx, store word there
    logic                     del;   // close the gap at idx
    logic [IDX_W-1:0]         idx;
    logic signed [WORD_W-1:0] word;
  } cell_cmd_t;

  // per-request outcome from the controller
  typedef struct packed {
    logic                 take;      // data comes from the cell at data_idx
    logic [IDX_W-1:0]     data_idx;
    logic [COUNT_W-1:0]   count_after;
    logic [STATUS_W-1:0]  status;
  } list_res_t;

endpackage

`default_nettype wire

// ===== rtl/pidl_cell.sv =====
// ----------------------------------------------------------------------------
// pidl_cell
// One slot of the list; loads from its left or right neighbor, or the new word.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_cell (
  input  wire                               clk_i,
  input  wire  [pidl_pkg::IDX_W-1:0]        cell_idx_i,
  input  wire  pidl_pkg::cell_cmd_t         cmd_i,
  input  wire  signed [pidl_pkg::WORD_W-1:0] left_word_i,
  input  wire  signed [pidl_pkg::WORD_W-1:0] right_word_i,
  output logic signed [pidl_pkg::WORD_W-1:0] word_o
);

  logic signed [pidl_pkg::WORD_W-1:0] word_q, word_d;

  // next value: shift toward the back on insert, toward the front on erase
  always_comb begin
    word_d = word_q;
    if (cmd_i.ins) begin
      if (cell_idx_i == cmd_i.idx) begin
        word_d = cmd_i.word;
      end else if (cell_idx_i > cmd_i.idx) begin
        word_d = left_word_i;
      end
    end else if (cmd_i.del) begin
      if (cell_idx_i >= cmd_i.idx) begin
        word_d = right_word_i;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

// ===== rtl/pidl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidl_ctrl
// Element count and decode of each request into a cell command and a result.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_ctrl (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 en_i,
  input  wire  [pidl_pkg::OP_W-1:0]           operation_i,
  input  wire  [pidl_pkg::POS_W-1:0]          position_i,
  input  wire  signed [pidl_pkg::WORD_W-1:0]  value_i,
  output pidl_pkg::cell_cmd_t                 cmd_o,
  output pidl_pkg::list_res_t                 res_o
);

  logic [pidl_pkg::CNT_W-1:0] count_q, count_d;
  logic                       full, empty;
  logic [pidl_pkg::CMP_W-1:0] pos_ext, cnt_ext, cnt_p1;
  logic [pidl_pkg::IDX_W-1:0] pos_idx, back_idx;
  logic                       ins, del;

  assign full     = (count_q == pidl_pkg::CNT_W'(pidl_pkg::CAPACITY));
  assign empty    = (count_q == '0);
  assign pos_ext  = pidl_pkg::CMP_W'(position_i);
  assign cnt_ext  = pidl_pkg::CMP_W'(count_q);
  assign cnt_p1   = cnt_ext + pidl_pkg::CMP_W'(1);
  assign pos_idx  = pidl_pkg::IDX_W'(position_i - pidl_pkg::POS_W'(1));
  assign back_idx = pidl_pkg::IDX_W'(count_q - pidl_pkg::CNT_W'(1));

  // decode request against the current count
  always_comb begin
    ins          = 1'b0;
    del          = 1'b0;
    cmd_o.idx    = '0;
    cmd_o.word   = value_i;
    res_o.take     = 1'b0;
    res_o.data_idx = '0;
    res_o.status   = pidl_pkg::ST_OK;
    count_d        = count_q;
    case (operation_i)
      pidl_pkg::OP_PUSH_BACK, pidl_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          res_o.status = pidl_pkg::ST_FULL;
        end else begin
          ins       = 1'b1;
          cmd_o.idx = (operation_i == pidl_pkg::OP_PUSH_BACK) ?
                      pidl_pkg::IDX_W'(count_q) : '0;
          count_d   = count_q + pidl_pkg::CNT_W'(1);
        end
      end
      pidl_pkg::OP_POP_BACK, pidl_pkg::OP_POP_FRONT: begin
        if (empty) begin
          res_o.status = pidl_pkg::ST_EMPTY;
        end else begin
          del            = 1'b1;
          res_o.take     = 1'b1;
          cmd_o.idx      = (operation_i == pidl_pkg::OP_POP_BACK) ? back_idx : '0;
          res_o.data_idx = cmd_o.idx;
          count_d        = count_q - pidl_pkg::CNT_W'(1);
        end
      end
      pidl_pkg::OP_INSERT: begin
        if (full) begin
          res_o.status = pidl_pkg::ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_p1) begin
          res_o.status = pidl_pkg::ST_RANGE;
        end else begin
          ins       = 1'b1;
          cmd_o.idx = pos_idx;
          count_d   = count_q + pidl_pkg::CNT_W'(1);
        end
      end
      pidl_pkg::OP_ERASE, pidl_pkg::OP_READ: begin
        if (empty) begin
          res_o.status = pidl_pkg::ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          res_o.status = pidl_pkg::ST_RANGE;
        end else begin
          res_o.take     = 1'b1;
          res_o.data_idx = pos_idx;
          cmd_o.idx      = pos_idx;
          if (operation_i == pidl_pkg::OP_ERASE) begin
            del     = 1'b1;
            count_d = count_q - pidl_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
    cmd_o.ins         = ins & en_i;
    cmd_o.del         = del & en_i;
    res_o.count_after = pidl_pkg::COUNT_W'(count_d);
  end

  // element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/positional_insert_delete_list_top.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list_top
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request: push back/front, pop back/front, insert,
//   erase or read at a 1-based position, plus the word to store.
//   m_axis returns one result per request: removed or read word, the count
//   after the request and a status (ok, full, empty, position out of range).
//   the result is registered as the request is taken; a new request is
//   taken every cycle unless a stalled result holds the output register,
//   since insert and erase move all later cells in parallel, each cell
//   loading from its neighbor in the same clock. a read or pop selects one
//   cell through a single mux before the result register.
//   reset empties the list (count zero); cell contents are not cleared.
//   when the receiver stalls the result is held in the output register and
//   s_axis_tready drops until it is taken, so no result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // operation[2:0], position[7:3], value[39:8]
  input  wire  [pidl_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // data_out[31:0], count_after[36:32], status[38:37], zero pad[39]
  output logic [pidl_pkg::OUT_W-1:0]   m_axis_tdata
);

  localparam int POS_LO = pidl_pkg::OP_W;
  localparam int VAL_LO = pidl_pkg::OP_W + pidl_pkg::POS_W;

  logic                                   accept;
  logic [pidl_pkg::OP_W-1:0]              operation;
  logic [pidl_pkg::POS_W-1:0]             position;
  logic signed [pidl_pkg::WORD_W-1:0]     value;
  pidl_pkg::cell_cmd_t                    cmd;
  pidl_pkg::list_res_t                    res;
  logic signed [pidl_pkg::WORD_W-1:0]     cell_word [pidl_pkg::CAPACITY];
  logic signed [pidl_pkg::WORD_W-1:0]     data_sel;

  logic                                   out_valid_q;
  logic signed [pidl_pkg::WORD_W-1:0]     data_q;
  logic [pidl_pkg::COUNT_W-1:0]           count_q;
  logic [pidl_pkg::STATUS_W-1:0]          status_q;

  // request unpack and handshake
  assign operation     = s_axis_tdata[pidl_pkg::OP_W-1:0];
  assign position      = s_axis_tdata[POS_LO +: pidl_pkg::POS_W];
  assign value         = s_axis_tdata[VAL_LO +: pidl_pkg::WORD_W];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pidl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .operation_i (operation),
    .position_i  (position),
    .value_i     (value),
    .cmd_o       (cmd),
    .res_o       (res)
  );

  // row of cells, each wired to its two neighbors
  for (genvar i = 0; i < pidl_pkg::CAPACITY; i++) begin : g_cell
    logic signed [pidl_pkg::WORD_W-1:0] left_word, right_word;
    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = cell_word[i-1];
    end
    if (i == pidl_pkg::CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = cell_word[i+1];
    end
    pidl_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (pidl_pkg::IDX_W'(i)),
      .cmd_i        (cmd),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .word_o       (cell_word[i])
    );
  end

  // removed or read word
  assign data_sel = res.take ? cell_word[res.data_idx] : '0;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q   <= data_sel;
      count_q  <= res.count_after;
      status_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(pidl_pkg::OUT_W - pidl_pkg::OUT_BITS){1'b0}},
                          status_q, count_q, data_q};

endmodule

`default_nettype wire

// ===== tb/pidl_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pidl_tb_pkg
// Result type and scoreboard for the positional insert/delete list bench.
// A queue of words mirrors the list contents, and each accepted request is
// turned into one expected result that waits for the block's answer.
// ----------------------------------------------------------------------------

package pidl_tb_pkg;

  import pidl_pkg::*;

  // code 7 is not an operation; the block must leave the list alone
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;
  } list_result_t;

  class list_scoreboard;
    logic signed [WORD_W-1:0] cells[$];
    list_result_t             pending[$];
    int                       mismatches;
    int                       requests;
    int                       results;
    int                       peak_fill;
    int                       status_hits[4];

    // apply one request to the mirrored list and return what it yields
    function list_result_t apply_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                    logic signed [WORD_W-1:0] word);
      list_result_t r;
      int           fill;
      int           place;
      r     = '0;
      fill  = cells.size();
      place = int'(pos);
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (fill >= CAPACITY) r.status = ST_FULL;
          else if (op == OP_PUSH_BACK) cells.push_back(word);
          else cells.push_front(word);
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          if (fill == 0) r.status = ST_EMPTY;
          else if (op == OP_POP_BACK) r.data = cells.pop_back();
          else r.data = cells.pop_front();
        end
        OP_INSERT: begin
          // fullness wins over a bad position
          if (fill >= CAPACITY) r.status = ST_FULL;
          else if (place < 1 || place > fill + 1) r.status = ST_RANGE;
          else cells.insert(place - 1, word);
        end
        OP_ERASE, OP_READ: begin
          // emptiness wins over a bad position
          if (fill == 0) r.status = ST_EMPTY;
          else if (place < 1 || place > fill) r.status = ST_RANGE;
          else begin
            r.data = cells[place - 1];
            if (op == OP_ERASE) cells.delete(place - 1);
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(cells.size());
      return r;
    endfunction

    // accepted request: unpack, predict, queue the expected result
    function void note_request(logic [IN_W-1:0] beat);
      list_result_t r;
      r = apply_op(beat[OP_W-1:0], beat[OP_W+POS_W-1:OP_W],
                   beat[OP_W+POS_W+WORD_W-1:OP_W+POS_W]);
      pending.push_back(r);
      requests++;
      status_hits[r.status]++;
      if (cells.size() > peak_fill) peak_fill = cells.size();
    endfunction

    // accepted result: compare with the oldest expectation
    function void check_result(logic [OUT_W-1:0] beat);
      list_result_t got;
      list_result_t want;
      got.data   = beat[WORD_W-1:0];
      got.count  = beat[WORD_W+COUNT_W-1:WORD_W];
      got.status = beat[WORD_W+COUNT_W+STATUS_W-1:WORD_W+COUNT_W];
      results++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with no request waiting: data %0d count %0d status %0d",
                   results, got.data, got.count, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data || got.count !== want.count ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result %0d mismatch: expected data %0d count %0d status %0d, ",
                 results, want.data, want.count, want.status);
          $display("got data %0d count %0d status %0d",
                   got.data, got.count, got.status);
        end
      end
    endfunction

    function int fill_level();
      return cells.size();
    endfunction

    function int waiting();
      return pending.size();
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream bench for the positional insert/delete list.
// A directed opening hits the empty and bad-position cases and the
// word extremes, then phases of random requests alternately grow, shrink
// and churn the list while both stream sides idle at random; every result
// is checked against a scoreboard that mirrors the list.
// ----------------------------------------------------------------------------

module tb;

  import pidl_pkg::*;
  import pidl_tb_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  int                send_idle_pct  = 17;
  int                recv_stall_pct = 17;
  int                quiet_cycles   = 0;

  list_scoreboard    sb = new();

  positional_insert_delete_list_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // observe both handshakes
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("no traffic for %0d cycles, giving up", IDLE_LIMIT);
      $display("** positional_insert_delete_list_top: FAILED **");
      $finish;
    end
  end

  // one request, entered and left at a falling edge
  task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic signed [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {word, pos, op};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // mostly random words, with the extremes mixed in
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // operation mix leans toward growth, shrinkage or neither
  function automatic logic [OP_W-1:0] pick_op(int bias);
    int roll;
    roll = $urandom_range(99);
    if (bias == 2) return OP_W'($urandom_range(7));
    if (roll >= 98) return OP_UNUSED;
    if (roll >= 84) return (roll[0]) ? OP_READ : OP_ERASE;
    if (bias == 0) begin
      if (roll < 28) return OP_PUSH_BACK;
      if (roll < 44) return OP_PUSH_FRONT;
      if (roll < 68) return OP_INSERT;
      return (roll < 76) ? OP_POP_BACK : OP_POP_FRONT;
    end
    if (roll < 28) return OP_POP_BACK;
    if (roll < 44) return OP_POP_FRONT;
    if (roll < 68) return OP_ERASE;
    return (roll < 76) ? OP_PUSH_BACK : OP_INSERT;
  endfunction

  // position inside the legal window most of the time
  function automatic logic [POS_W-1:0] pick_pos(logic [OP_W-1:0] op, int fill);
    if ($urandom_range(99) >= 80) return POS_W'($urandom_range(31));
    if (op == OP_INSERT) return POS_W'($urandom_range(fill + 1, 1));
    if (fill == 0) return POS_W'(1);
    return POS_W'($urandom_range(fill, 1));
  endfunction

  initial begin
    logic [OP_W-1:0] op;
    int              bias;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: every removal and read, the unused code, bad inserts
    send_request(OP_POP_BACK,  5'd0,  32'sd5);
    send_request(OP_POP_FRONT, 5'd31, 32'sd6);
    send_request(OP_ERASE,     5'd1,  32'sd7);
    send_request(OP_READ,      5'd1,  32'sd8);
    send_request(OP_UNUSED,    5'd31, '1);
    send_request(OP_INSERT,    5'd0,  32'sd9);
    send_request(OP_INSERT,    5'd2,  32'sd10);
    // build a short list, mostly from the word extremes
    send_request(OP_INSERT,     5'd1, 32'sh8000_0000);
    send_request(OP_PUSH_BACK,  5'd0, 32'sh7FFF_FFFF);
    send_request(OP_PUSH_FRONT, 5'd0, '1);
    send_request(OP_INSERT,     5'd4, 32'sh5555_AAAA);
    // positions at and past the ends
    send_request(OP_READ,   5'd0,  '0);
    send_request(OP_READ,   5'd5,  '0);
    send_request(OP_READ,   5'd31, '0);
    send_request(OP_READ,   5'd4,  '0);
    send_request(OP_ERASE,  5'd5,  '0);
    send_request(OP_INSERT, 5'd6,  '0);
    send_request(OP_ERASE,  5'd4,  '0);
    send_request(OP_ERASE,  5'd1,  '0);
    send_request(OP_INSERT, 5'd2,  32'sh0F0F_F0F0);
    send_request(OP_POP_FRONT, 5'd0, '0);
    send_request(OP_POP_BACK,  5'd0, '0);

    // random phases; the middle one runs with no idling anywhere
    for (int p = 0; p < PHASES; p++) begin
      bias           = p % 3;
      send_idle_pct  = (p == 4) ? 0 : 17;
      recv_stall_pct = (p == 4) ? 0 : 17;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = pick_op(bias);
        send_request(op, pick_pos(op, sb.fill_level()), pick_word());
      end
    end
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 17;

    // drain, then let the result register settle
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("run covered %0d requests and %0d results, list filled up to %0d of %0d",
             sb.requests, sb.results, sb.peak_fill, CAPACITY);
    $display("outcomes: ok %0d, full %0d, empty %0d, out of range %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_FULL],
             sb.status_hits[ST_EMPTY], sb.status_hits[ST_RANGE]);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("** positional_insert_delete_list_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.waiting());
      $display("** positional_insert_delete_list_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/pidl_ctrl.sv
rtl/positional_insert_delete_list_top.sv
tb/pidl_tb_pkg.sv
tb/tb.sv
